// File: src/bsa_pkg.sv
// shared constants, codes and types for the bitmap slot allocator
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int ROW_BITS  = 64;
    localparam int ROWS      = MAX_SLOTS / ROW_BITS;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int BIT_AW    = $clog2(ROW_BITS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_SLOTS);

    typedef enum logic {
        ACT_TAKE    = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_FULL     = 2'd1,
        ST_RELEASED = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef struct packed {
        t_action           action;
        logic [SLOT_W-1:0] release_index;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        t_status           status;
    } t_rsp;

    typedef struct packed {
        logic              found;
        logic              grant;
        logic [SLOT_W-1:0] slot;
    } t_find;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REL,
        S_OUT
    } t_state;

endpackage

// File: src/bsa_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module bsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bsa_find.sv
// lowest clear bit search over one map row and limit check
`timescale 1ns / 1ps

module bsa_find (
    input  logic [bsa_pkg::ROW_BITS-1:0] i_word,
    input  logic [bsa_pkg::ROW_AW-1:0]   i_row,
    input  logic [bsa_pkg::CNT_W-1:0]    i_limit,
    output bsa_pkg::t_find               o_find
);

    logic                       found;
    logic [bsa_pkg::BIT_AW-1:0] pos;
    logic [bsa_pkg::SLOT_W-1:0] slot;

    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int i = bsa_pkg::ROW_BITS - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                found = 1'b1;
                pos   = bsa_pkg::BIT_AW'(i);
            end
        end
    end

    assign slot         = {i_row, pos};
    assign o_find.found = found;
    assign o_find.grant = found && (bsa_pkg::CNT_W'(slot) < i_limit);
    assign o_find.slot  = slot;

endmodule

// File: src/bitmap_slot_allocator.sv
// first fit slot allocator over an occupancy bitmap
`timescale 1ns / 1ps

// usage
//   input channel: i_in_valid / o_in_stall carry a take or release request
//   output channel: o_out_valid / i_out_stall carry one result per request
//   config: i_cfg_we/i_cfg_wdata set entry_count; user keeps to idle, unchecked
// timing
//   the map is held as 16 rows of 64 slots in one ram; a take reads one row
//   a cycle through the shared search unit until a row has a clear bit or
//   the last row is read; a release reads then rewrites its row, an out of
//   range release goes straight to its result; one request is in flight at
//   a time and the next is taken in the cycle after the result transfer
// reset
//   per-row valid flops clear at once, so every slot reads free right after
//   reset with no clearing pass; entry_count returns to 1024
// stall
//   the result sits in its output register until the transfer completes;
//   no new request is taken before that

module bitmap_slot_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bsa_pkg::t_req               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output bsa_pkg::t_rsp               o_out_data,
    input  logic                        i_cfg_we,
    input  logic [bsa_pkg::CNT_W-1:0]   i_cfg_wdata
);

    bsa_pkg::t_state              r_state, n_state;
    logic [bsa_pkg::ROW_AW-1:0]   r_row, n_row;
    logic [bsa_pkg::BIT_AW-1:0]   r_bit, n_bit;
    logic [bsa_pkg::ROWS-1:0]     r_vld, n_vld;
    logic [bsa_pkg::CNT_W-1:0]    r_entry_count;
    bsa_pkg::t_rsp                r_out, n_out;

    logic                         ram_we;
    logic [bsa_pkg::ROW_AW-1:0]   ram_waddr;
    logic [bsa_pkg::ROW_BITS-1:0] ram_wdata;
    logic [bsa_pkg::ROW_AW-1:0]   ram_raddr;
    logic [bsa_pkg::ROW_BITS-1:0] ram_rdata;
    logic [bsa_pkg::ROW_BITS-1:0] word;
    bsa_pkg::t_find               find;

    bsa_ram #(
        .WIDTH (bsa_pkg::ROW_BITS),
        .DEPTH (bsa_pkg::ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // rows never written read as free
    assign word = r_vld[r_row] ? ram_rdata : '0;

    bsa_find u_find (
        .i_word  (word),
        .i_row   (r_row),
        .i_limit (r_entry_count),
        .o_find  (find)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bsa_pkg::S_IDLE;
            r_vld         <= '0;
            r_entry_count <= bsa_pkg::CNT_RESET;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_bit <= n_bit;
        r_out <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_bit     = r_bit;
        n_vld     = r_vld;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_row;
        ram_wdata = word;
        ram_raddr = r_row;
        case (r_state)
            bsa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.action == bsa_pkg::ACT_TAKE) begin
                        n_row     = '0;
                        ram_raddr = '0;
                        n_state   = bsa_pkg::S_SCAN;
                    end else begin
                        n_out.slot_index = i_in_data.release_index;
                        if (bsa_pkg::CNT_W'(i_in_data.release_index) < r_entry_count) begin
                            n_row = i_in_data.release_index[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_AW];
                            n_bit     = i_in_data.release_index[bsa_pkg::BIT_AW-1:0];
                            ram_raddr = n_row;
                            n_state   = bsa_pkg::S_REL;
                        end else begin
                            n_out.status = bsa_pkg::ST_RANGE;
                            n_state      = bsa_pkg::S_OUT;
                        end
                    end
                end
            end
            bsa_pkg::S_SCAN: begin
                if (find.found) begin
                    if (find.grant) begin
                        ram_we       = 1'b1;
                        ram_wdata    = word | (bsa_pkg::ROW_BITS'(1)
                                       << find.slot[bsa_pkg::BIT_AW-1:0]);
                        n_vld[r_row] = 1'b1;
                        n_out.slot_index = find.slot;
                        n_out.status     = bsa_pkg::ST_GRANTED;
                    end else begin
                        n_out.slot_index = '0;
                        n_out.status     = bsa_pkg::ST_FULL;
                    end
                    n_state = bsa_pkg::S_OUT;
                end else if (r_row == bsa_pkg::ROW_AW'(bsa_pkg::ROWS - 1)) begin
                    n_out.slot_index = '0;
                    n_out.status     = bsa_pkg::ST_FULL;
                    n_state          = bsa_pkg::S_OUT;
                end else begin
                    n_row     = r_row + 1'b1;
                    ram_raddr = n_row;
                end
            end
            bsa_pkg::S_REL: begin
                ram_we       = 1'b1;
                ram_wdata    = word & ~(bsa_pkg::ROW_BITS'(1) << r_bit);
                n_vld[r_row] = 1'b1;
                n_out.status = bsa_pkg::ST_RELEASED;
                n_state      = bsa_pkg::S_OUT;
            end
            bsa_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_state = bsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != bsa_pkg::S_IDLE);
    assign o_out_valid = (r_state == bsa_pkg::S_OUT);
    assign o_out_data  = r_out;

    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == bsa_pkg::ST_GRANTED)
        |-> (bsa_pkg::CNT_W'(o_out_data.slot_index) < r_entry_count))
        else $error("granted slot at or above entry count");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("result repeated after transfer");

    a_write_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == bsa_pkg::S_SCAN || r_state == bsa_pkg::S_REL))
        else $error("map write outside scan or release");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsa_pkg::S_SCAN && n_state == bsa_pkg::S_OUT && !ram_we)
        |=> (r_out.status == bsa_pkg::ST_FULL))
        else $error("scan ended without grant but status not full");

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for the bitmap slot allocator: directed, stress and random phases
`timescale 1ns / 1ps

module tb_top;
    import bsa_pkg::*;

    localparam int HOLD_LEN = 300;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_req                i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_rsp                o_out_data;
    logic                i_cfg_we    = 1'b0;
    logic [CNT_W-1:0]    i_cfg_wdata = '0;

    // allocator shadow state
    logic [MAX_SLOTS-1:0] slot_used = '0;
    logic [CNT_W-1:0]     cur_limit = CNT_RESET;
    t_rsp                 pending_rsp[$];
    t_rsp                 want;
    int                   err_count = 0;

    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_ticket = 0;
    int hold_seen   = 0;
    int hold_left   = 0;

    bitmap_slot_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_rsp predict_alloc(input t_req req);
        t_rsp rsp;
        int   lim;
        int   s;
        logic hit;
        lim = (int'(cur_limit) > MAX_SLOTS) ? MAX_SLOTS : int'(cur_limit);
        rsp.slot_index = '0;
        rsp.status = ST_FULL;
        if (req.action == ACT_TAKE) begin
            s = 0;
            hit = 1'b0;
            while (!hit && s < MAX_SLOTS) begin
                if (!slot_used[s]) begin
                    hit = 1'b1;
                end else begin
                    s++;
                end
            end
            // first clear bit sits at or above the limit: treated as full
            if (hit && s < lim) begin
                slot_used[s] = 1'b1;
                rsp.slot_index = SLOT_W'(s);
                rsp.status = ST_GRANTED;
            end
        end else begin
            rsp.slot_index = req.release_index;
            if (int'(req.release_index) < lim) begin
                slot_used[req.release_index] = 1'b0;
                rsp.status = ST_RELEASED;
            end else begin
                rsp.status = ST_RANGE;
            end
        end
        return rsp;
    endfunction

    task automatic send_req(input t_action act, input logic [SLOT_W-1:0] idx);
        t_req req;
        req.action = act;
        req.release_index = idx;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_rsp.push_back(predict_alloc(req));
    endtask

    task automatic take_slot();
        send_req(ACT_TAKE, SLOT_W'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [CNT_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_limit = value;
    endtask

    task automatic release_all();
        wait_drained();
        set_limit(CNT_W'(MAX_SLOTS));
        for (int s = 0; s < MAX_SLOTS; s++) begin
            if (slot_used[s]) send_req(ACT_RELEASE, SLOT_W'(s));
        end
        wait_drained();
    endtask

    task automatic test_basic();
        take_slot();
        take_slot();
        take_slot();
        send_req(ACT_RELEASE, SLOT_W'(1));
        take_slot();
        // release of a slot that is already free
        send_req(ACT_RELEASE, SLOT_W'(500));
        send_req(ACT_RELEASE, '1);
        send_req(ACT_TAKE, '1);
        send_req(ACT_TAKE, '0);
        wait_drained();
    endtask

    task automatic test_limit_extremes();
        set_limit('0);
        take_slot();
        send_req(ACT_RELEASE, '0);
        send_req(ACT_RELEASE, '1);
        wait_drained();
        // above the slot count acts as the slot count
        set_limit('1);
        take_slot();
        send_req(ACT_RELEASE, '1);
        send_req(ACT_RELEASE, '0);
        wait_drained();
        set_limit(CNT_W'(MAX_SLOTS + 1));
        take_slot();
        wait_drained();
    endtask

    task automatic test_padding_bits();
        release_all();
        set_limit(CNT_W'(12));
        repeat (13) take_slot();
        send_req(ACT_RELEASE, SLOT_W'(12));
        wait_drained();
        // map survives a limit change
        set_limit(CNT_W'(MAX_SLOTS));
        repeat (4) take_slot();
        wait_drained();
        set_limit(CNT_W'(10));
        take_slot();
        send_req(ACT_RELEASE, SLOT_W'(14));
        wait_drained();
        set_limit(CNT_W'(MAX_SLOTS));
        send_req(ACT_RELEASE, SLOT_W'(14));
        take_slot();
        wait_drained();
    endtask

    // leaves the map full for the phases that follow
    task automatic test_fill_map();
        release_all();
        repeat (MAX_SLOTS + 2) take_slot();
        wait_drained();
    endtask

    task automatic test_output_holdoff();
        wait_drained();
        gap_pct = 0;
        stall_pct = 0;
        hold_ticket++;
        repeat (6) take_slot();
        send_req(ACT_RELEASE, SLOT_W'(2));
        // sender pauses until every result is back
        wait_drained();
        repeat (3) take_slot();
        wait_drained();
    endtask

    task automatic run_random(input int pct_gap, input int pct_stall,
                              input logic [CNT_W-1:0] lim, input int count);
        int eff;
        int pick;
        int tries;
        int roll;
        wait_drained();
        gap_pct = pct_gap;
        stall_pct = pct_stall;
        set_limit(lim);
        eff = (int'(lim) > MAX_SLOTS) ? MAX_SLOTS : int'(lim);
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                take_slot();
            end else if (roll < 90) begin
                pick = $urandom_range(eff - 1);
                tries = 0;
                while (!slot_used[pick] && tries < 8) begin
                    pick = $urandom_range(eff - 1);
                    tries++;
                end
                send_req(ACT_RELEASE, SLOT_W'(pick));
            end else begin
                send_req(ACT_RELEASE, SLOT_W'($urandom));
            end
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen <= hold_ticket;
            hold_left <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected result transfer slot_index %0d status %0d",
                       o_out_data.slot_index, o_out_data.status);
                err_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_out_data.slot_index !== want.slot_index) begin
                    $error("slot_index expected %0d actual %0d",
                           want.slot_index, o_out_data.slot_index);
                    err_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_out_data.status);
                    err_count++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic();
        test_limit_extremes();
        test_padding_bits();
        test_fill_map();
        test_output_holdoff();
        run_random(0, 0, CNT_W'(1), 60);
        run_random(0, 0, CNT_W'($urandom_range(64, 8)), 120);
        run_random(53, 0, CNT_W'($urandom_range(40, 2)), 120);
        run_random(0, 53, '1, 120);
        run_random(37, 37, CNT_W'($urandom_range(300, 1)), 120);
        wait_drained();
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
